// File: rtl/xcrc_pkg.sv
// Shared types and constants of the XMODEM-CRC receiver.
// No dependencies; every file of the block but xcrc_if imports it.
package xcrc_pkg;

    localparam logic [7:0]  CH_SOH = 8'h01;
    localparam logic [7:0]  CH_EOT = 8'h04;
    localparam logic [7:0]  CH_ACK = 8'h06;
    localparam logic [7:0]  CH_NAK = 8'h15;
    localparam logic [7:0]  CH_CAN = 8'h18;
    localparam logic [7:0]  CH_C   = 8'h43;
    localparam logic [7:0]  CH_PAD = 8'h1A;

    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [3:0]  MAX_ATTEMPTS_RESET = 4'd6;

    // Configuration register indexes
    localparam logic        REG_START_WITH_NAK = 1'b0;
    localparam logic        REG_MAX_ATTEMPTS   = 1'b1;

    // Session status codes
    localparam logic [1:0]  ST_RUNNING = 2'd0;
    localparam logic [1:0]  ST_EOT     = 2'd1;
    localparam logic [1:0]  ST_CAN     = 2'd2;
    localparam logic [1:0]  ST_FAILED  = 2'd3;

    typedef struct packed {
        logic       start_with_nak;
        logic [3:0] max_attempts;
    } cfg_t;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       data_valid;
        logic [6:0] data_index;
        logic [7:0] data_byte;
        logic       data_keep;
        logic       block_done;
        logic       block_good;
        logic [1:0] session_status;
    } result_t;

endpackage

// File: rtl/xcrc_if.sv
// Channel interfaces of the XMODEM-CRC receiver: input item, result item
// and configuration write. No dependencies.
interface xcrc_item_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] rx_byte;

    modport source (output valid, output opcode, output rx_byte, input ready);
    modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

interface xcrc_result_if;
    logic       valid;
    logic       ready;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       data_valid;
    logic [6:0] data_index;
    logic [7:0] data_byte;
    logic       data_keep;
    logic       block_done;
    logic       block_good;
    logic [1:0] session_status;

    modport source (output valid, output tx_valid, output tx_byte, output data_valid,
                    output data_index, output data_byte, output data_keep,
                    output block_done, output block_good, output session_status,
                    input ready);
    modport sink   (input valid, input tx_valid, input tx_byte, input data_valid,
                    input data_index, input data_byte, input data_keep,
                    input block_done, input block_good, input session_status,
                    output ready);
endinterface

interface xcrc_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [3:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/xcrc_crc.sv
// Byte-wide CRC-16/XMODEM update (poly 0x1021, MSB first, no reflection).
// Depends on xcrc_pkg.
module xcrc_crc (
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);
    import xcrc_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        crc_out = c;
    end

endmodule

// File: rtl/xcrc_ctrl.sv
// Session and block sequencer: consumes one item per step and forms its result.
// Depends on xcrc_pkg and xcrc_crc.
module xcrc_ctrl #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic             opcode,
    input  logic [7:0]       rx_byte,
    input  xcrc_pkg::cfg_t   cfg,
    output xcrc_pkg::result_t res
);
    import xcrc_pkg::*;

    localparam int IDX_W = $clog2(BLOCK_BYTES);
    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(BLOCK_BYTES - 1);

    typedef enum logic [3:0] {
        PH_IDLE, PH_HANDSHAKE, PH_NUM, PH_COMP, PH_DATA, PH_CRCH, PH_CRCL,
        PH_NEXT, PH_END_EOT, PH_END_CAN, PH_FAILED
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [3:0]       attempts_reg, attempts_next;
    logic [IDX_W-1:0] index_reg, index_next;
    logic [7:0]       number_reg, number_next;
    logic [7:0]       complement_reg, complement_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       crc_high_reg, crc_high_next;
    logic [15:0]      crc_updated;
    logic [7:0]       start_ch;
    logic             good;

    xcrc_crc u_crc (
        .crc_in  (crc_reg),
        .data    (rx_byte),
        .crc_out (crc_updated)
    );

    assign start_ch = cfg.start_with_nak ? CH_NAK : CH_C;
    assign good = (~number_reg == complement_reg) && (crc_high_reg == crc_reg[15:8])
                  && (rx_byte == crc_reg[7:0]);

    always_comb
    begin
        phase_next      = phase_reg;
        attempts_next   = attempts_reg;
        index_next      = index_reg;
        number_next     = number_reg;
        complement_next = complement_reg;
        crc_next        = crc_reg;
        crc_high_next   = crc_high_reg;
        res             = '0;

        if (!opcode)
        begin
            // start command restarts the session from any phase
            phase_next    = PH_HANDSHAKE;
            attempts_next = 4'd1;
            res.tx_valid  = 1'b1;
            res.tx_byte   = start_ch;
        end
        else
        begin
            unique case (phase_reg)
                PH_HANDSHAKE:
                begin
                    if (rx_byte == CH_SOH)
                        phase_next = PH_NUM;
                    else if (attempts_reg < cfg.max_attempts)
                    begin
                        attempts_next = attempts_reg + 4'd1;
                        res.tx_valid  = 1'b1;
                        res.tx_byte   = start_ch;
                    end
                    else
                        phase_next = PH_FAILED;
                end
                PH_NUM:
                begin
                    number_next = rx_byte;
                    crc_next    = '0;
                    index_next  = '0;
                    phase_next  = PH_COMP;
                end
                PH_COMP:
                begin
                    complement_next = rx_byte;
                    phase_next      = PH_DATA;
                end
                PH_DATA:
                begin
                    res.data_valid = 1'b1;
                    res.data_index = 7'(index_reg);
                    res.data_byte  = rx_byte;
                    res.data_keep  = (rx_byte != CH_PAD);
                    crc_next       = crc_updated;
                    if (index_reg == LAST_INDEX)
                    begin
                        index_next = '0;
                        phase_next = PH_CRCH;
                    end
                    else
                        index_next = index_reg + IDX_W'(1);
                end
                PH_CRCH:
                begin
                    crc_high_next = rx_byte;
                    phase_next    = PH_CRCL;
                end
                PH_CRCL:
                begin
                    res.block_done = 1'b1;
                    res.block_good = good;
                    res.tx_valid   = 1'b1;
                    res.tx_byte    = good ? CH_ACK : CH_NAK;
                    phase_next     = PH_NEXT;
                end
                PH_NEXT:
                begin
                    if (rx_byte == CH_EOT || rx_byte == CH_CAN)
                    begin
                        res.tx_valid = 1'b1;
                        res.tx_byte  = CH_ACK;
                        phase_next   = (rx_byte == CH_EOT) ? PH_END_EOT : PH_END_CAN;
                    end
                    else
                        phase_next = PH_NUM;
                end
                default:
                begin
                end
            endcase
        end

        unique case (phase_next)
            PH_END_EOT: res.session_status = ST_EOT;
            PH_END_CAN: res.session_status = ST_CAN;
            PH_FAILED:  res.session_status = ST_FAILED;
            default:    res.session_status = ST_RUNNING;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            attempts_reg   <= '0;
            index_reg      <= '0;
            number_reg     <= '0;
            complement_reg <= '0;
            crc_reg        <= '0;
            crc_high_reg   <= '0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            attempts_reg   <= attempts_next;
            index_reg      <= index_next;
            number_reg     <= number_next;
            complement_reg <= complement_next;
            crc_reg        <= crc_next;
            crc_high_reg   <= crc_high_next;
        end
    end

endmodule

// File: rtl/xcrc_skid.sv
// Result register with a skid stage, so an item is taken while a result waits.
// Depends on xcrc_pkg.
module xcrc_skid (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  xcrc_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output xcrc_pkg::result_t out_data
);
    import xcrc_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_reg;
    result_t skid_reg;
    logic    main_load;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;
    assign main_load = !main_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_load)
        begin
            main_valid_reg <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (main_load)
            main_reg <= skid_valid_reg ? skid_reg : in_data;
        else if (in_valid && in_ready)
            skid_reg <= in_data;
    end

endmodule

// File: rtl/xmodem_crc_receiver.sv
// Top level of the XMODEM-CRC receiver.
// Depends on xcrc_pkg, xcrc_if, xcrc_crc, xcrc_ctrl and xcrc_skid.
//
// Usage:
//   item    - one item per start command (opcode 0) or per line byte (opcode 1).
//   result  - exactly one result item per input item, in order: control byte
//             to send ('C', NAK or ACK), payload byte with index and keep flag,
//             block verdict and session status.
//   cfg     - register writes (index 0 start_with_nak, 1 max_attempts); always
//             ready, write only while no item is in flight.
// Output: the result of an item is registered in the result register, or in
//   the skid stage while an earlier result waits.
// Throughput: one item per cycle while item.ready is high; the state step and the byte-wide CRC update
//   sit in one combinational stage between the session registers and the
//   result register.
// Stall: a two-entry output (result register plus skid stage) keeps taking
//   items while one result waits; item.ready drops once both entries hold.
// Reset: rst_n clears the session to idle, the CRC and counters to zero and
//   the registers to 'C' start with six attempts; no clearing pass is needed.
module xmodem_crc_receiver #(
    parameter int BLOCK_BYTES = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    xcrc_item_if.sink     item,
    xcrc_result_if.source result,
    xcrc_cfg_if.sink      cfg
);
    import xcrc_pkg::*;

    cfg_t    cfg_reg;
    result_t step_res;
    result_t out_res;
    logic    item_ready;
    logic    step;

    // Configuration: always ready, decode the register index.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_with_nak <= 1'b0;
            cfg_reg.max_attempts   <= MAX_ATTEMPTS_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_START_WITH_NAK: cfg_reg.start_with_nak <= cfg.data[0];
                REG_MAX_ATTEMPTS:   cfg_reg.max_attempts   <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

    // Advance the session on every accepted item.
    assign item.ready = item_ready;
    assign step       = item.valid && item_ready;

    xcrc_ctrl #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .opcode  (item.opcode),
        .rx_byte (item.rx_byte),
        .cfg     (cfg_reg),
        .res     (step_res)
    );

    // Hold results in the output register and skid stage.
    xcrc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (item_ready),
        .in_data   (step_res),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (out_res)
    );

    assign result.tx_valid       = out_res.tx_valid;
    assign result.tx_byte        = out_res.tx_byte;
    assign result.data_valid     = out_res.data_valid;
    assign result.data_index     = out_res.data_index;
    assign result.data_byte      = out_res.data_byte;
    assign result.data_keep      = out_res.data_keep;
    assign result.block_done     = out_res.block_done;
    assign result.block_good     = out_res.block_good;
    assign result.session_status = out_res.session_status;

endmodule
